@@ rtl/lav_pkg.sv @@
// Look-at view matrix: shared widths, types and arithmetic helpers.
// Used by lav_normalize and look_at_view_matrix_unit. No dependencies.
package lav_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // block scaling puts the largest magnitude in [2^(SCL_W-1), 2^SCL_W)
  localparam int SCL_W     = 30;

  localparam int UNIT_W    = FRAC_BITS + 2;             // signed unit component
  localparam int XPRD_W    = UNIT_W + SCL_W + 1;        // signed cross product term
  localparam int DIFF_W    = WORD_BITS + 1;
  localparam int NRM_IN_W  = (DIFF_W > XPRD_W - 1) ? DIFF_W : XPRD_W - 1;
  localparam int BL_W      = $clog2(NRM_IN_W + 1);
  localparam int SQ_W      = 2 * SCL_W + 2;             // sum of squares
  localparam int LEN_W     = SCL_W + 1;                 // floor sqrt of the sum
  localparam int NUM_W     = SCL_W + FRAC_BITS + 1;     // divider numerator
  localparam int Q_W       = FRAC_BITS + 1;             // quotient magnitude
  localparam int TRAW_W    = 2 * UNIT_W + 1;            // side x forward, unrounded
  localparam int TUP_W     = UNIT_W + 1;
  localparam int DP_W      = TUP_W + WORD_BITS;         // one dot product term
  localparam int DS_W      = DP_W + 2;                  // sum of three terms

  localparam logic [WORD_BITS-1:0] ONE_WORD = WORD_BITS'(1) << FRAC_BITS;

  typedef logic [NRM_IN_W-1:0] nmag_t;

  typedef struct packed {
    logic [2:0]               neg;
    logic [2:0][NRM_IN_W-1:0] mag;
  } nvec_t;

  typedef logic [2:0][UNIT_W-1:0] uvec_t;

  // travels alongside a vector through the normalizer
  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] eye;
    logic [2:0][WORD_BITS-1:0] aux;
    logic                      degen;
  } side_t;

  // number of significant bits
  function automatic logic [BL_W-1:0] bit_len(input nmag_t v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int i = 0; i < NRM_IN_W; i++) begin
      if (v[i]) n = BL_W'(i + 1);
    end
    return n;
  endfunction

  // scale by 2^(SCL_W - n); bits falling off the right are dropped
  function automatic nmag_t block_shift(input nmag_t v, input logic [BL_W-1:0] n);
    logic [NRM_IN_W+SCL_W-1:0] w;
    w = {v, {SCL_W{1'b0}}} >> n;
    return w[NRM_IN_W-1:0];
  endfunction

  // round half up, then clamp to the signed word range
  function automatic logic [WORD_BITS-1:0] rnd_sat(input logic signed [DS_W-1:0] s);
    logic signed [DS_W:0] t;
    logic signed [DS_W:0] rc;
    logic signed [DS_W:0] hi_lim;
    logic signed [DS_W:0] lo_lim;
    rc = '0;
    rc[FRAC_BITS-1] = 1'b1;
    hi_lim = {{(DS_W + 2 - WORD_BITS){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    lo_lim = ~hi_lim;
    t = {s[DS_W-1], s};
    t = t + rc;
    t = t >>> FRAC_BITS;
    if (t > hi_lim) return {1'b0, {(WORD_BITS - 1){1'b1}}};
    if (t < lo_lim) return {1'b1, {(WORD_BITS - 1){1'b0}}};
    return t[WORD_BITS-1:0];
  endfunction

endpackage

@@ rtl/look_at_view_matrix_unit.sv @@
// Look-at view matrix unit: top level, row serializer and cross/dot stages.
// Depends on lav_pkg and lav_normalize (two instances).
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o   | eye_*, target_*, upward_* (Q16.16)
//  out     | out_valid_o / out_ready_i | row_index, col_*, last_row, degenerate
//
// Each item gives four row transfers, so when the output drains freely the single
// output channel sets how often an item is taken.
// The path from the input to row 0 runs through two 54-stage normalizers.
// Reset clears only valid and row state. A stall at the output freezes the
// whole pipeline only once its last stage holds an item; bubbles ahead close.
module look_at_view_matrix_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lav_pkg::WORD_BITS-1:0] eye_x_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] eye_y_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] eye_z_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] target_x_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] target_y_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] target_z_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] upward_x_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] upward_y_i,
  input  logic signed [lav_pkg::WORD_BITS-1:0] upward_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          row_index_o,
  output logic signed [lav_pkg::WORD_BITS-1:0] col_zero_o,
  output logic signed [lav_pkg::WORD_BITS-1:0] col_one_o,
  output logic signed [lav_pkg::WORD_BITS-1:0] col_two_o,
  output logic signed [lav_pkg::WORD_BITS-1:0] col_three_o,
  output logic                                last_row_o,
  output logic                                degenerate_o
);
  import lav_pkg::*;

  localparam logic [1:0] LAST_ROW = 2'd3;
  localparam int         NA       = 5;
  localparam int         NB       = 6;

  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] eye;
    logic [2:0]                uneg;
    logic [2:0][NRM_IN_W-1:0]  umag;
    logic [NRM_IN_W-1:0]       umax;
    logic [BL_W-1:0]           ulen;
    uvec_t                     fwd;
    uvec_t                     side;
    logic [5:0][XPRD_W-1:0]    xp;
    nvec_t                     cvec;
    logic [2:0][TRAW_W-1:0]    traw;
    logic [2:0][TUP_W-1:0]     tup;
    logic [2:0][DP_W-1:0]      dpa;
    logic [2:0][DP_W-1:0]      dpb;
    logic [2:0][DP_W-1:0]      dpc;
    logic [DS_W-1:0]           dsa;
    logic [DS_W-1:0]           dsb;
    logic [DS_W-1:0]           dsc;
    logic [2:0][WORD_BITS-1:0] dot;
    logic                      degen;
  } item_t;

  logic                      en;
  logic                      o_free;
  logic                      o_load;

  logic                      in_v_q;
  logic [2:0][WORD_BITS-1:0] in_eye_q, in_tgt_q, in_up_q;

  logic                      d1_v_q;
  nvec_t                     d1_vec_q, d1_vec_d;
  side_t                     d1_side_q, d1_side_d;

  logic                      n1_v, n2_v;
  uvec_t                     n1_unit, n2_unit;
  logic                      n1_zero, n2_zero;
  side_t                     n1_side, n2_side, n2_side_in;

  item_t                     a_q [NA];
  item_t                     a_d [NA];
  logic [NA-1:0]             a_v_q;
  item_t                     b_q [NB];
  item_t                     b_d [NB];
  logic [NB-1:0]             b_v_q;

  logic                      o_v_q;
  logic [1:0]                o_row_q;
  item_t                     o_q;

  // the pipeline holds only when its last stage cannot hand over
  assign o_free     = !o_v_q || (out_ready_i && o_row_q == LAST_ROW);
  assign en         = !b_v_q[NB-1] || o_free;
  assign o_load     = b_v_q[NB-1] && o_free;
  assign in_ready_o = en;

  // target - eye in sign-magnitude
  always_comb begin
    logic signed [WORD_BITS:0] df;
    logic signed [WORD_BITS:0] dm;
    d1_vec_d = '0;
    for (int i = 0; i < 3; i++) begin
      df = $signed({in_tgt_q[i][WORD_BITS-1], in_tgt_q[i]})
         - $signed({in_eye_q[i][WORD_BITS-1], in_eye_q[i]});
      dm = df[WORD_BITS] ? -df : df;
      d1_vec_d.neg[i] = df[WORD_BITS];
      d1_vec_d.mag[i] = NRM_IN_W'(dm);
    end
    d1_side_d.eye   = in_eye_q;
    d1_side_d.aux   = in_up_q;
    d1_side_d.degen = 1'b0;
  end

  lav_normalize u_nrm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_v_q),
    .vec_i   (d1_vec_q),
    .side_i  (d1_side_q),
    .valid_o (n1_v),
    .unit_o  (n1_unit),
    .zero_o  (n1_zero),
    .side_o  (n1_side)
  );

  // up vector block scale, then forward x up
  always_comb begin
    logic [WORD_BITS-1:0]  w;
    logic [WORD_BITS-1:0]  wm;
    logic signed [SCL_W:0] ue;
    logic signed [SCL_W:0] us [3];
    logic signed [XPRD_W:0] dd;
    logic signed [XPRD_W:0] dm;
    a_d[0]       = '0;
    a_d[0].eye   = n1_side.eye;
    a_d[0].fwd   = n1_unit;
    a_d[0].degen = n1_zero;
    for (int i = 0; i < 3; i++) begin
      w  = n1_side.aux[i];
      wm = ~w + 1'b1;
      a_d[0].uneg[i] = w[WORD_BITS-1];
      a_d[0].umag[i] = w[WORD_BITS-1] ? NRM_IN_W'(wm) : NRM_IN_W'(w);
    end
    a_d[0].umax = a_d[0].umag[0];
    if (a_d[0].umag[1] > a_d[0].umax) a_d[0].umax = a_d[0].umag[1];
    if (a_d[0].umag[2] > a_d[0].umax) a_d[0].umax = a_d[0].umag[2];

    a_d[1]      = a_q[0];
    a_d[1].ulen = bit_len(a_q[0].umax);

    a_d[2] = a_q[1];
    for (int i = 0; i < 3; i++) begin
      a_d[2].umag[i] = block_shift(a_q[1].umag[i], a_q[1].ulen);
    end

    a_d[3] = a_q[2];
    for (int i = 0; i < 3; i++) begin
      ue    = {1'b0, a_q[2].umag[i][SCL_W-1:0]};
      us[i] = a_q[2].uneg[i] ? -ue : ue;
    end
    a_d[3].xp[0] = $signed(a_q[2].fwd[1]) * us[2];
    a_d[3].xp[1] = $signed(a_q[2].fwd[2]) * us[1];
    a_d[3].xp[2] = $signed(a_q[2].fwd[2]) * us[0];
    a_d[3].xp[3] = $signed(a_q[2].fwd[0]) * us[2];
    a_d[3].xp[4] = $signed(a_q[2].fwd[0]) * us[1];
    a_d[3].xp[5] = $signed(a_q[2].fwd[1]) * us[0];

    a_d[4] = a_q[3];
    for (int c = 0; c < 3; c++) begin
      dd = $signed(a_q[3].xp[2*c]) - $signed(a_q[3].xp[2*c+1]);
      dm = dd[XPRD_W] ? -dd : dd;
      a_d[4].cvec.neg[c] = dd[XPRD_W];
      a_d[4].cvec.mag[c] = NRM_IN_W'(dm);
    end
  end

  always_comb begin
    n2_side_in.eye   = a_q[NA-1].eye;
    n2_side_in.degen = a_q[NA-1].degen;
    for (int i = 0; i < 3; i++) begin
      n2_side_in.aux[i] = WORD_BITS'($signed(a_q[NA-1].fwd[i]));
    end
  end

  lav_normalize u_nrm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_v_q[NA-1]),
    .vec_i   (a_q[NA-1].cvec),
    .side_i  (n2_side_in),
    .valid_o (n2_v),
    .unit_o  (n2_unit),
    .zero_o  (n2_zero),
    .side_o  (n2_side)
  );

  // true up = side x forward, and the three translation dot products
  always_comb begin
    uvec_t                    f;
    logic signed [DP_W-1:0]   pr;
    logic signed [XPRD_W:0]   dd;
    logic signed [TRAW_W-1:0] tt;
    logic [TRAW_W-1:0]        tm;
    logic [TRAW_W-1:0]        rm;
    logic signed [TUP_W-1:0]  tp;
    for (int i = 0; i < 3; i++) f[i] = n2_side.aux[i][UNIT_W-1:0];
    b_d[0]       = '0;
    b_d[0].eye   = n2_side.eye;
    b_d[0].fwd   = f;
    b_d[0].side  = n2_unit;
    b_d[0].degen = n2_side.degen | n2_zero;
    b_d[0].xp[0] = $signed(n2_unit[1]) * $signed(f[2]);
    b_d[0].xp[1] = $signed(n2_unit[2]) * $signed(f[1]);
    b_d[0].xp[2] = $signed(n2_unit[2]) * $signed(f[0]);
    b_d[0].xp[3] = $signed(n2_unit[0]) * $signed(f[2]);
    b_d[0].xp[4] = $signed(n2_unit[0]) * $signed(f[1]);
    b_d[0].xp[5] = $signed(n2_unit[1]) * $signed(f[0]);
    for (int i = 0; i < 3; i++) begin
      pr = $signed(n2_unit[i]) * $signed(n2_side.eye[i]);
      b_d[0].dpa[i] = -pr;
      pr = $signed(f[i]) * $signed(n2_side.eye[i]);
      b_d[0].dpb[i] = pr;
    end

    b_d[1] = b_q[0];
    for (int c = 0; c < 3; c++) begin
      dd = $signed(b_q[0].xp[2*c]) - $signed(b_q[0].xp[2*c+1]);
      b_d[1].traw[c] = TRAW_W'(dd);
    end
    b_d[1].dsa = $signed(b_q[0].dpa[0]) + $signed(b_q[0].dpa[1]) + $signed(b_q[0].dpa[2]);
    b_d[1].dsb = $signed(b_q[0].dpb[0]) + $signed(b_q[0].dpb[1]) + $signed(b_q[0].dpb[2]);

    // magnitude rounding, ties away from zero
    b_d[2] = b_q[1];
    for (int i = 0; i < 3; i++) begin
      tt = $signed(b_q[1].traw[i]);
      tm = tt[TRAW_W-1] ? -tt : tt;
      rm = (tm + (TRAW_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      tp = TUP_W'(rm);
      b_d[2].tup[i] = tt[TRAW_W-1] ? -tp : tp;
    end
    b_d[2].dot[0] = rnd_sat(b_q[1].dsa);
    b_d[2].dot[2] = rnd_sat(b_q[1].dsb);

    b_d[3] = b_q[2];
    for (int i = 0; i < 3; i++) begin
      pr = $signed(b_q[2].tup[i]) * $signed(b_q[2].eye[i]);
      b_d[3].dpc[i] = -pr;
    end

    b_d[4]     = b_q[3];
    b_d[4].dsc = $signed(b_q[3].dpc[0]) + $signed(b_q[3].dpc[1]) + $signed(b_q[3].dpc[2]);

    b_d[5]        = b_q[4];
    b_d[5].dot[1] = rnd_sat(b_q[4].dsc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      a_v_q  <= '0;
      b_v_q  <= '0;
    end else if (en) begin
      in_v_q <= in_valid_i;
      d1_v_q <= in_v_q;
      a_v_q  <= {a_v_q[NA-2:0], n1_v};
      b_v_q  <= {b_v_q[NB-2:0], n2_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_eye_q  <= {eye_z_i, eye_y_i, eye_x_i};
      in_tgt_q  <= {target_z_i, target_y_i, target_x_i};
      in_up_q   <= {upward_z_i, upward_y_i, upward_x_i};
      d1_vec_q  <= d1_vec_d;
      d1_side_q <= d1_side_d;
      a_q       <= a_d;
      b_q       <= b_d;
    end
    if (o_load) o_q <= b_q[NB-1];
  end

  // row serializer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q   <= 1'b0;
      o_row_q <= '0;
    end else if (o_load) begin
      o_v_q   <= 1'b1;
      o_row_q <= '0;
    end else if (o_v_q && out_ready_i) begin
      if (o_row_q == LAST_ROW) o_v_q <= 1'b0;
      o_row_q <= o_row_q + 2'd1;
    end
  end

  always_comb begin
    logic signed [UNIT_W-1:0] nf;
    nf = -$signed(o_q.fwd[o_row_q]);
    if (o_row_q == LAST_ROW) begin
      col_zero_o  = o_q.dot[0];
      col_one_o   = o_q.dot[1];
      col_two_o   = o_q.dot[2];
      col_three_o = ONE_WORD;
    end else begin
      col_zero_o  = WORD_BITS'($signed(o_q.side[o_row_q]));
      col_one_o   = WORD_BITS'($signed(o_q.tup[o_row_q]));
      col_two_o   = WORD_BITS'(nf);
      col_three_o = '0;
    end
  end

  assign out_valid_o  = o_v_q;
  assign row_index_o  = o_row_q;
  assign last_row_o   = (o_row_q == LAST_ROW);
  assign degenerate_o = o_q.degen;

`ifndef ASSERT_OFF
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      out_valid_o && row_index_o == 2'($past(row_index_o) + 2'd1))
    else $error("row sequence broken");

  a_degen_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=> degenerate_o == $past(degenerate_o))
    else $error("degenerate flag changed within an item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> b_v_q[NB-1] && o_v_q)
    else $error("input stalled without a full output");
`endif

endmodule

@@ rtl/lav_normalize.sv @@
// Pipelined vector normalizer: block scale, sum of squares, one root bit
// per stage, then one quotient bit per stage. Depends on lav_pkg.
module lav_normalize (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  lav_pkg::nvec_t vec_i,
  input  lav_pkg::side_t side_i,
  output logic           valid_o,
  output lav_pkg::uvec_t unit_o,
  output logic           zero_o,
  output lav_pkg::side_t side_o
);
  import lav_pkg::*;

  localparam int SQ_FIRST  = 5;
  localparam int SQ_LAST   = SQ_FIRST + LEN_W - 1;
  localparam int NUM_ST    = SQ_LAST + 1;
  localparam int DIV_FIRST = NUM_ST + 1;
  localparam int NST       = DIV_FIRST + Q_W;

  typedef struct packed {
    logic [2:0]                neg;
    logic [2:0][NRM_IN_W-1:0]  mag;
    logic [NRM_IN_W-1:0]       mx;
    logic [BL_W-1:0]           bl;
    logic [2:0][2*SCL_W-1:0]   sq;
    logic [SQ_W-1:0]           x;
    logic [SQ_W-1:0]           res;
    logic [2:0][NUM_W-1:0]     rem;
    logic [2:0][Q_W-1:0]       q;
  } nst_t;

  nst_t           st_q [NST];
  nst_t           st_d [NST];
  side_t          sd_q [NST];
  logic [NST-1:0] v_q;

  always_comb begin
    logic [SQ_W-1:0]  bitv;
    logic [SQ_W-1:0]  trial;
    logic [NUM_W:0]   dv;
    int               k;
    st_d[0]     = '0;
    st_d[0].neg = vec_i.neg;
    st_d[0].mag = vec_i.mag;
    st_d[0].mx  = vec_i.mag[0];
    if (vec_i.mag[1] > st_d[0].mx) st_d[0].mx = vec_i.mag[1];
    if (vec_i.mag[2] > st_d[0].mx) st_d[0].mx = vec_i.mag[2];
    for (int s = 1; s < NST; s++) begin
      st_d[s] = st_q[s-1];
      if (s == 1) begin
        st_d[s].bl = bit_len(st_q[s-1].mx);
      end else if (s == 2) begin
        for (int i = 0; i < 3; i++) begin
          st_d[s].mag[i] = block_shift(st_q[s-1].mag[i], st_q[s-1].bl);
        end
      end else if (s == 3) begin
        for (int i = 0; i < 3; i++) begin
          st_d[s].sq[i] = st_q[s-1].mag[i][SCL_W-1:0] * st_q[s-1].mag[i][SCL_W-1:0];
        end
      end else if (s == 4) begin
        st_d[s].x   = SQ_W'(st_q[s-1].sq[0]) + SQ_W'(st_q[s-1].sq[1])
                    + SQ_W'(st_q[s-1].sq[2]);
        st_d[s].res = '0;
      end else if (s <= SQ_LAST) begin
        // restoring square root, one result bit per stage
        bitv  = SQ_W'(1) << (2 * (SQ_LAST - s));
        trial = st_q[s-1].res + bitv;
        if (st_q[s-1].x >= trial) begin
          st_d[s].x   = st_q[s-1].x - trial;
          st_d[s].res = (st_q[s-1].res >> 1) + bitv;
        end else begin
          st_d[s].res = st_q[s-1].res >> 1;
        end
      end else if (s == NUM_ST) begin
        for (int i = 0; i < 3; i++) begin
          st_d[s].rem[i] = (NUM_W'(st_q[s-1].mag[i][SCL_W-1:0]) << FRAC_BITS)
                         + NUM_W'(st_q[s-1].res[LEN_W-1:1]);
        end
        st_d[s].q = '0;
      end else begin
        k = NST - 1 - s;
        for (int i = 0; i < 3; i++) begin
          dv = (NUM_W + 1)'(st_q[s-1].res[LEN_W-1:0]) << k;
          if ({1'b0, st_q[s-1].rem[i]} >= dv) begin
            st_d[s].rem[i]  = st_q[s-1].rem[i] - dv[NUM_W-1:0];
            st_d[s].q[i][k] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q    <= st_d;
      sd_q[0] <= side_i;
      for (int s = 1; s < NST; s++) sd_q[s] <= sd_q[s-1];
    end
  end

  always_comb begin
    logic [UNIT_W-1:0] m;
    zero_o = (st_q[NST-1].mx == '0);
    for (int i = 0; i < 3; i++) begin
      m = UNIT_W'(st_q[NST-1].q[i]);
      if (zero_o) unit_o[i] = '0;
      else if (st_q[NST-1].neg[i]) unit_o[i] = ~m + 1'b1;
      else unit_o[i] = m;
    end
  end

  assign valid_o = v_q[NST-1];
  assign side_o  = sd_q[NST-1];

endmodule
